// File: hdl/glyph_row_width_scaler_core_macros.svh
// ----------------------------------------------------------------------------
// glyph row width scaler assertion macros
// shared concurrent assertion forms for the scaler checker
// ----------------------------------------------------------------------------
`ifndef GLYPH_ROW_WIDTH_SCALER_CORE_MACROS_SVH
`define GLYPH_ROW_WIDTH_SCALER_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define GRWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define GRWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/grws_pkg.sv
// ----------------------------------------------------------------------------
// grws_pkg
// field widths and parameter defaults of the glyph row width scaler
// ----------------------------------------------------------------------------
package grws_pkg;

    // word field widths
    localparam int ROW_W    = 32;
    localparam int SRC_W_W  = 6;
    localparam int TGT_W_W  = 7;
    localparam int SCALED_W = 64;

    // default geometry limits
    localparam int SRC_MAX_WIDTH_DEF = 32;
    localparam int DST_MAX_WIDTH_DEF = 64;

endpackage

// File: hdl/grws_if.sv
// ----------------------------------------------------------------------------
// grws_if
// valid/ready channels of the glyph row width scaler
// ----------------------------------------------------------------------------

// source row channel
interface grws_in_if;
    logic                             valid;
    logic                             ready;
    logic [grws_pkg::ROW_W-1:0]       source_row;
    logic [grws_pkg::SRC_W_W-1:0]     source_width;
    logic [grws_pkg::TGT_W_W-1:0]     target_width;

    modport source (output valid, output source_row, output source_width,
                    output target_width, input ready);
    modport sink   (input valid, input source_row, input source_width,
                    input target_width, output ready);
endinterface

// scaled row channel
interface grws_out_if;
    logic                             valid;
    logic                             ready;
    logic [grws_pkg::SCALED_W-1:0]    scaled_row;

    modport source (output valid, output scaled_row, input ready);
    modport sink   (input valid, input scaled_row, output ready);
endinterface

// File: hdl/glyph_row_width_scaler_core.sv
// ----------------------------------------------------------------------------
// glyph_row_width_scaler_core
// nearest neighbor rescale of one glyph scanline to a wanted pixel count
// ----------------------------------------------------------------------------
// usage
//   i_row carries one word per scanline: source_row (bit 0 leftmost pixel),
//   source_width and target_width; widths out of range are clamped.
//   o_row returns one word per input word: scaled_row, bits at and above the
//   target width are zero.
//   the pipeline holds one clamp stage, two width divide stages, then one
//   stage per source pixel position.
//   throughput is one word per cycle unless o_row stalls; the pixel pipeline sets it.
//   a stalled o_row freezes the whole pipeline, i_row.ready drops with it and
//   no word is lost or repeated; an empty output slot keeps i_row.ready high.
//   reset (synchronous, active low) empties the pipeline at once; no
//   clearing pass follows and the block accepts words in the next cycle.
// ----------------------------------------------------------------------------
module glyph_row_width_scaler_core #(
    parameter int SRC_MAX_WIDTH = grws_pkg::SRC_MAX_WIDTH_DEF,
    parameter int DST_MAX_WIDTH = grws_pkg::DST_MAX_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    grws_in_if.sink   i_row,
    grws_out_if.source o_row
);

    // internal widths follow the geometry limits
    localparam int SW_W  = $clog2(SRC_MAX_WIDTH + 1);
    localparam int TW_W  = $clog2(DST_MAX_WIDTH + 1);
    localparam int SFW   = grws_pkg::SRC_W_W;
    localparam int TFW   = grws_pkg::TGT_W_W;
    localparam int OUT_W = grws_pkg::SCALED_W;

    // quotient bits below this index are resolved in the second divide stage
    localparam int DIV_LO = TW_W / 2;

    localparam logic [SFW-1:0] SW_LIM = SFW'(SRC_MAX_WIDTH);
    localparam logic [TFW-1:0] TW_LIM = TFW'(DST_MAX_WIDTH);

    // clamped word after the first stage
    typedef struct packed {
        logic [SRC_MAX_WIDTH-1:0] row;
        logic [SW_W-1:0]          sw;
        logic [TW_W-1:0]          tw;
    } t_front;

    // word with the upper quotient bits resolved
    typedef struct packed {
        logic [SRC_MAX_WIDTH-1:0] row;
        logic [SW_W-1:0]          sw;
        logic [TW_W-1:0]          tw;
        logic [SW_W-1:0]          rem;    // partial remainder
        logic [TW_W-1:0]          quo;    // upper quotient bits
    } t_div;

    // running state of the accumulator walk
    typedef struct packed {
        logic [SRC_MAX_WIDTH-1:0] row;
        logic [SW_W-1:0]          sw;     // source width
        logic [TW_W-1:0]          q0;     // whole outputs per source pixel
        logic [SW_W-1:0]          r0;     // fractional step of the accumulator
        logic [SW_W-1:0]          acc;    // accumulator remainder, below sw
        logic [TW_W-1:0]          idx;    // next output pixel
        logic                     orbit;  // or of pixels not yet emitted
        logic [DST_MAX_WIDTH-1:0] res;
    } t_pix;

    // the whole pipe moves together; it holds only when the output is stalled
    logic adv;

    logic   r_front_vld;
    t_front r_front;
    t_front n_front;

    logic   r_div_vld;
    t_div   r_div;
    t_div   n_div;

    logic [SRC_MAX_WIDTH:0] r_pix_vld;
    t_pix                   r_pix [0:SRC_MAX_WIDTH];
    t_pix                   n_pix [0:SRC_MAX_WIDTH];

    assign adv         = !r_pix_vld[SRC_MAX_WIDTH] || o_row.ready;
    assign i_row.ready = adv;

    // clamp widths into their legal ranges
    always_comb begin
        n_front.row = i_row.source_row[SRC_MAX_WIDTH-1:0];
        if (i_row.source_width == '0) begin
            n_front.sw = SW_W'(1);
        end else if (i_row.source_width > SW_LIM) begin
            n_front.sw = SW_W'(SRC_MAX_WIDTH);
        end else begin
            n_front.sw = i_row.source_width[SW_W-1:0];
        end
        if (i_row.target_width == '0) begin
            n_front.tw = TW_W'(1);
        end else if (i_row.target_width > TW_LIM) begin
            n_front.tw = TW_W'(DST_MAX_WIDTH);
        end else begin
            n_front.tw = i_row.target_width[TW_W-1:0];
        end
    end

    // restoring divide tw / sw, one quotient bit per step: upper bits
    always_comb begin
        logic [SW_W:0]   rem;
        logic [TW_W-1:0] quo;
        rem = '0;
        quo = '0;
        for (int b = TW_W - 1; b >= DIV_LO; b--) begin
            rem = {rem[SW_W-1:0], r_front.tw[b]};
            if (rem >= {1'b0, r_front.sw}) begin
                rem    = rem - {1'b0, r_front.sw};
                quo[b] = 1'b1;
            end
        end
        n_div.row = r_front.row;
        n_div.sw  = r_front.sw;
        n_div.tw  = r_front.tw;
        n_div.rem = rem[SW_W-1:0];
        n_div.quo = quo;
    end

    // lower quotient bits, then seed the accumulator walk
    always_comb begin
        logic [SW_W:0]   rem;
        logic [TW_W-1:0] quo;
        rem = {1'b0, r_div.rem};
        quo = r_div.quo;
        for (int b = DIV_LO - 1; b >= 0; b--) begin
            rem = {rem[SW_W-1:0], r_div.tw[b]};
            if (rem >= {1'b0, r_div.sw}) begin
                rem    = rem - {1'b0, r_div.sw};
                quo[b] = 1'b1;
            end
        end
        n_pix[0].row   = r_div.row;
        n_pix[0].sw    = r_div.sw;
        n_pix[0].q0    = quo;
        n_pix[0].r0    = rem[SW_W-1:0];
        n_pix[0].acc   = '0;
        n_pix[0].idx   = '0;
        n_pix[0].orbit = 1'b0;
        n_pix[0].res   = '0;
    end

    // one stage per source pixel: gain tw, emit the or over every output
    // pixel the accumulator passes, then clear the or
    for (genvar k = 0; k < SRC_MAX_WIDTH; k++) begin : g_pix
        localparam logic [SW_W-1:0] PIX = SW_W'(k);

        always_comb begin
            logic [SW_W:0]            sum;
            logic                     cy;
            logic [TW_W:0]            nxt;
            logic                     lit;
            logic [DST_MAX_WIDTH-1:0] span;
            n_pix[k+1] = r_pix[k];
            sum  = {1'b0, r_pix[k].acc} + {1'b0, r_pix[k].r0};
            cy   = (sum >= {1'b0, r_pix[k].sw});
            nxt  = {1'b0, r_pix[k].idx} + {1'b0, r_pix[k].q0} + (TW_W + 1)'(cy);
            lit  = r_pix[k].orbit | r_pix[k].row[k];
            for (int j = 0; j < DST_MAX_WIDTH; j++) begin
                span[j] = ({1'b0, r_pix[k].idx} <= (TW_W + 1)'(j))
                       && ((TW_W + 1)'(j) < nxt);
            end
            if (PIX < r_pix[k].sw) begin
                if (cy) begin
                    n_pix[k+1].acc = SW_W'(sum - {1'b0, r_pix[k].sw});
                end else begin
                    n_pix[k+1].acc = sum[SW_W-1:0];
                end
                n_pix[k+1].idx = nxt[TW_W-1:0];
                if (nxt != {1'b0, r_pix[k].idx}) begin
                    if (lit) begin
                        n_pix[k+1].res = r_pix[k].res | span;
                    end
                    n_pix[k+1].orbit = 1'b0;
                end else begin
                    n_pix[k+1].orbit = lit;
                end
            end
        end
    end

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_vld <= 1'b0;
            r_div_vld   <= 1'b0;
            r_pix_vld   <= '0;
        end else if (adv) begin
            r_front_vld <= i_row.valid;
            r_div_vld   <= r_front_vld;
            r_pix_vld   <= {r_pix_vld[SRC_MAX_WIDTH-1:0], r_div_vld};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_front <= n_front;
            r_div   <= n_div;
            for (int k = 0; k <= SRC_MAX_WIDTH; k++) begin
                r_pix[k] <= n_pix[k];
            end
        end
    end

    // the last pixel stage doubles as the output register
    assign o_row.valid      = r_pix_vld[SRC_MAX_WIDTH];
    assign o_row.scaled_row = OUT_W'(r_pix[SRC_MAX_WIDTH].res);

endmodule

// File: hdl/grws_checker.sv
// ----------------------------------------------------------------------------
// grws_checker
// port level checks of the glyph row width scaler, bound to the top level
// ----------------------------------------------------------------------------
`include "glyph_row_width_scaler_core_macros.svh"

module grws_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [grws_pkg::SCALED_W-1:0] i_out_row
);

    // a held word stays offered
    `GRWS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "scaled word dropped while stalled")
    // a held word keeps its value
    `GRWS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_row), "scaled word changed while stalled")
    // with the output slot empty the pipe must be taking words
    `GRWS_ASSERT_NOW(a_in_open, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input blocked with empty output")
    // reset leaves the pipe empty
    `GRWS_ASSERT_NOW(a_rst_empty, i_clk, i_rst_n, !$past(i_rst_n), !i_out_valid, "word offered right after reset")

endmodule

bind glyph_row_width_scaler_core grws_checker u_grws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_row.ready),
    .i_out_valid (o_row.valid),
    .i_out_ready (o_row.ready),
    .i_out_row   (o_row.scaled_row)
);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for glyph_row_width_scaler_core: directed and random
// scanline words go in over i_row, every scaled word is compared against a
// behavioral scaler kept in this file, with random idle and stall bursts
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import grws_pkg::*;

    localparam int SRC_LIMIT   = SRC_MAX_WIDTH_DEF;
    localparam int DST_LIMIT   = DST_MAX_WIDTH_DEF;
    localparam int DRAIN_WAIT  = SRC_LIMIT + 8;   // pipeline depth plus margin
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOW_LIMIT  = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    grws_in_if  row_in ();
    grws_out_if row_out ();

    glyph_row_width_scaler_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_in),
        .o_row   (row_out)
    );

    always #5 i_clk = ~i_clk;

    // expected scaled words, oldest first
    logic [SCALED_W-1:0] scaled_row_q[$];

    int rows_sent     = 0;
    int words_checked = 0;
    int err_count     = 0;
    int cycle_count   = 0;
    int gap_pct       = 0;   // chance of an idle burst before a word
    bit stall_on      = 1'b0;
    int stall_left    = 0;

    // mask of the lowest w pixels
    function automatic logic [63:0] pixel_mask(int w);
        if (w >= 64) return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    // behavioral scaler: clamp, mask, then pass, double or accumulate
    function automatic logic [SCALED_W-1:0] scale_glyph_row(logic [ROW_W-1:0] src_row,
                                                            logic [SRC_W_W-1:0] src_w,
                                                            logic [TGT_W_W-1:0] tgt_w);
        int          sw;
        int          tw;
        int          acc;
        int          idx;
        logic        pending;
        logic [63:0] row;
        logic [63:0] res;
        sw = src_w;
        tw = tgt_w;
        if (sw < 1) sw = 1;
        else if (sw > SRC_LIMIT) sw = SRC_LIMIT;
        if (tw < 1) tw = 1;
        else if (tw > DST_LIMIT) tw = DST_LIMIT;
        row = 64'(src_row) & pixel_mask(sw);
        res = '0;
        if (sw == tw) begin
            res = row;
        end else if (tw == 2 * sw) begin
            for (int n = 0; n < 32; n++) begin
                res[2*n]   = row[n];
                res[2*n+1] = row[n];
            end
        end else begin
            acc     = 0;
            idx     = 0;
            pending = 1'b0;
            for (int n = 0; n < sw; n++) begin
                pending = pending | row[n];
                acc += tw;
                if (acc >= sw) begin
                    while (acc >= sw) begin
                        if (idx < 64) res[idx] = res[idx] | pending;
                        idx++;
                        acc -= sw;
                    end
                    pending = 1'b0;
                end
            end
            // leftover source pixels land on the last output pixel
            if (pending) res[(tw - 1) & 63] = 1'b1;
        end
        return res & pixel_mask(tw);
    endfunction

    // drive one scanline word, optionally after an idle burst
    task automatic send_row(logic [ROW_W-1:0] src_row, logic [SRC_W_W-1:0] src_w,
                            logic [TGT_W_W-1:0] tgt_w);
        @(negedge i_clk);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            row_in.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        row_in.valid        <= 1'b1;
        row_in.source_row   <= src_row;
        row_in.source_width <= src_w;
        row_in.target_width <= tgt_w;
        do @(posedge i_clk); while (!row_in.ready);
        scaled_row_q.push_back(scale_glyph_row(src_row, src_w, tgt_w));
        rows_sent++;
    endtask

    task automatic note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
        err_count++;
        if (err_count <= SHOW_LIMIT)
            $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, act_v);
    endtask

    // output side stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            row_out.ready <= 1'b0;
        end else begin
            row_out.ready <= 1'b1;
        end
    end

    // compare each accepted scaled word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && row_out.valid && row_out.ready) begin
            if (scaled_row_q.size() == 0) begin
                note_mismatch("unexpected word", '0, row_out.scaled_row);
            end else begin
                if (row_out.scaled_row !== scaled_row_q[0])
                    note_mismatch("scaled_row", scaled_row_q[0], row_out.scaled_row);
                void'(scaled_row_q.pop_front());
            end
            words_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // equal widths, including bits beyond the source width
    task automatic test_passthrough();
        send_row(32'hFFFF_FFFF, 6'd32, 7'd32);
        send_row(32'h0000_0001, 6'd1, 7'd1);
        send_row(32'hA5A5_A5A5, 6'd8, 7'd8);
    endtask

    // exact doubling
    task automatic test_doubling();
        send_row(32'hFFFF_FFFF, 6'd32, 7'd64);
        send_row(32'h8000_0001, 6'd32, 7'd64);
        send_row(32'h0000_0001, 6'd1, 7'd2);
        send_row(32'hFFFF_FFFD, 6'd3, 7'd6);
    endtask

    // accumulator path, both shrinking and stretching
    task automatic test_accumulate();
        send_row(32'hFFFF_FFFF, 6'd32, 7'd1);
        send_row(32'h8000_0000, 6'd32, 7'd3);
        send_row(32'h0000_0001, 6'd1, 7'd64);
        send_row(32'h0000_0003, 6'd2, 7'd5);
        send_row(32'hDEAD_BEEF, 6'd32, 7'd63);
        send_row(32'h0000_0010, 6'd5, 7'd3);
        send_row(32'h0000_0002, 6'd3, 7'd1);
        send_row(32'h0000_0000, 6'd32, 7'd17);
    endtask

    // widths out of range clamp to the limits
    task automatic test_width_clamp();
        send_row(32'hFFFF_FFFF, 6'd0, 7'd5);
        send_row(32'h1234_5678, 6'd33, 7'd40);
        send_row(32'hCAFE_F00D, 6'd63, 7'd64);
        send_row(32'hFFFF_FFFF, 6'd7, 7'd0);
        send_row(32'h5555_5555, 6'd20, 7'd65);
        send_row(32'hAAAA_AAAA, 6'd32, 7'd127);
        send_row(32'h0F0F_0F0F, 6'd0, 7'd0);
    endtask

    // random words: mostly legal ratios, some out of range widths
    task automatic send_random_rows(int count);
        logic [ROW_W-1:0]   src_row;
        logic [SRC_W_W-1:0] src_w;
        logic [TGT_W_W-1:0] tgt_w;
        for (int k = 0; k < count; k++) begin
            src_w = SRC_W_W'($urandom_range(1, SRC_LIMIT));
            case ($urandom_range(0, 9))
                0:       tgt_w = TGT_W_W'(src_w);
                1, 2:    tgt_w = TGT_W_W'(2 * src_w);
                3:       tgt_w = TGT_W_W'($urandom_range(1, src_w));
                9: begin
                    src_w = SRC_W_W'($urandom_range(0, 63));
                    tgt_w = TGT_W_W'($urandom_range(0, 127));
                end
                default: tgt_w = TGT_W_W'($urandom_range(1, DST_LIMIT));
            endcase
            case ($urandom_range(0, 15))
                0:       src_row = '1;
                1:       src_row = '0;
                2:       src_row = ROW_W'(1) << $urandom_range(0, ROW_W - 1);
                default: src_row = $urandom;
            endcase
            send_row(src_row, src_w, tgt_w);
        end
    endtask

    // random mix with idle and stall bursts on both sides
    task automatic test_random_mix();
        gap_pct  = 30;
        stall_on = 1'b1;
        send_random_rows(800);
    endtask

    // closing stretch at full rate, no idling anywhere
    task automatic test_back_to_back();
        gap_pct  = 0;
        stall_on = 1'b0;
        send_random_rows(100);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        row_in.valid        = 1'b0;
        row_in.source_row   = '0;
        row_in.source_width = SRC_W_W'(1);
        row_in.target_width = TGT_W_W'(1);
        row_out.ready       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough();
        test_doubling();
        test_accumulate();
        test_width_clamp();
        test_random_mix();
        test_back_to_back();

        @(negedge i_clk);
        row_in.valid <= 1'b0;
        wait (scaled_row_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (scaled_row_q.size() != 0) begin
            err_count++;
            $display("%0d scaled words never arrived", scaled_row_q.size());
        end

        $display("covered pass-through, doubling, accumulate and clamped widths");
        $display("%0d rows sent, %0d scaled words checked, %0d mismatches",
                 rows_sent, words_checked, err_count);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/grws_pkg.sv
hdl/grws_if.sv
hdl/glyph_row_width_scaler_core.sv
hdl/grws_checker.sv
verif/testbench.sv
